// ===== rtl/qspd_pkg.sv =====
// shared types and character constants of the query string pair decoder
package qspd_pkg;

	// special characters of the query string
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// most results one input item can cause
	localparam int unsigned MAX_RES = 4;

	// result kind codes
	typedef enum logic [1:0] {
		KIND_NAME  = 2'd0,
		KIND_VALUE = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	// one decoded result
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} res_t;

	// all results caused by one input item, slot 0 first
	typedef struct packed {
		logic [2:0]              cnt;
		res_t [MAX_RES-1:0]      res;
	} bundle_t;

endpackage

// ===== rtl/qspd_front.sv =====
// front end: scans input items, tracks pair and escape state, builds result bundles
module qspd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	input  logic                q_full,
	output logic                bundle_push,
	output qspd_pkg::bundle_t   bundle
);

	typedef enum logic [1:0] {
		ESC_NONE  = 2'd0,
		ESC_PCT   = 2'd1,
		ESC_DIGIT = 2'd2
	} esc_t;

	esc_t       phase_q, phase_d;
	logic [7:0] held_q, held_d;
	logic       value_q, value_d;
	logic       seen_q, seen_d;
	logic       accept;

	// hex digit check, either case
	function automatic logic is_hex(logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
		       (c >= 8'h61 && c <= 8'h66);
	endfunction

	// nibble of a hex digit; letters share their low nibble in both cases
	function automatic logic [3:0] hex_val(logic [7:0] c);
		return (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
	endfunction

	// append one result unless it belongs to a pair with an empty name or the bundle is full
	function automatic qspd_pkg::bundle_t add(qspd_pkg::bundle_t b, qspd_pkg::kind_t k,
			logic [7:0] d, logic ns);
		qspd_pkg::bundle_t r;
		r = b;
		if ((k == qspd_pkg::KIND_NAME || ns) && b.cnt < 3'(qspd_pkg::MAX_RES)) begin
			r.res[b.cnt[1:0]].kind = k;
			r.res[b.cnt[1:0]].data = d;
			r.cnt = b.cnt + 3'd1;
		end
		return r;
	endfunction

	assign accept = in_valid && !q_full;

	// decode one item into its bundle and the next state
	always_comb begin
		qspd_pkg::bundle_t b;
		qspd_pkg::kind_t   pk;
		esc_t              ph;
		logic [7:0]        hd;
		logic              iv, ns, consumed, closed;
		b        = '0;
		ph       = phase_q;
		hd       = held_q;
		iv       = value_q;
		ns       = seen_q;
		consumed = 1'b0;
		closed   = 1'b0;
		if (!iv && in_byte != qspd_pkg::CH_AMP && in_byte != qspd_pkg::CH_EQ) begin
			ns = 1'b1;
		end
		pk = iv ? qspd_pkg::KIND_VALUE : qspd_pkg::KIND_NAME;
		// pending escape: complete it or give it back literally
		priority if (ph == ESC_PCT) begin
			if (is_hex(in_byte)) begin
				ph       = ESC_DIGIT;
				hd       = in_byte;
				consumed = 1'b1;
			end else begin
				b  = add(b, pk, qspd_pkg::CH_PCT, ns);
				ph = ESC_NONE;
			end
		end else if (ph == ESC_DIGIT) begin
			if (is_hex(in_byte)) begin
				b        = add(b, pk, {hex_val(hd), hex_val(in_byte)}, ns);
				ph       = ESC_NONE;
				hd       = '0;
				consumed = 1'b1;
			end else begin
				b  = add(b, pk, qspd_pkg::CH_PCT, ns);
				b  = add(b, pk, hd, ns);
				ph = ESC_NONE;
			end
		end else begin
		end
		// ordinary byte handling
		if (!consumed) begin
			priority if (in_byte == qspd_pkg::CH_AMP) begin
				b      = add(b, qspd_pkg::KIND_END, 8'h00, ns);
				iv     = 1'b0;
				ns     = 1'b0;
				closed = 1'b1;
			end else if (in_byte == qspd_pkg::CH_EQ && !iv) begin
				iv = 1'b1;
			end else if (in_byte == qspd_pkg::CH_PLUS) begin
				b = add(b, pk, qspd_pkg::CH_SPACE, ns);
			end else if (in_byte == qspd_pkg::CH_PCT) begin
				ph = ESC_PCT;
			end else begin
				b = add(b, pk, in_byte, ns);
			end
		end
		// end of string: flush escape, close the open pair, clear state
		if (in_last) begin
			pk = iv ? qspd_pkg::KIND_VALUE : qspd_pkg::KIND_NAME;
			if (ph == ESC_PCT || ph == ESC_DIGIT) begin
				b = add(b, pk, qspd_pkg::CH_PCT, ns);
			end
			if (ph == ESC_DIGIT) begin
				b = add(b, pk, hd, ns);
			end
			if (!closed) begin
				b = add(b, qspd_pkg::KIND_END, 8'h00, ns);
			end
			ph = ESC_NONE;
			hd = '0;
			iv = 1'b0;
			ns = 1'b0;
		end
		bundle  = b;
		phase_d = ph;
		held_d  = hd;
		value_d = iv;
		seen_d  = ns;
	end

	assign bundle_push = accept && (bundle.cnt != 3'd0);

	// scan state, updated on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ESC_NONE;
			held_q  <= '0;
			value_q <= 1'b0;
			seen_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			value_q <= value_d;
			seen_q  <= seen_d;
		end
	end

	// end of string returns the scanner to its reset state
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |=> phase_q == ESC_NONE && !value_q && !seen_q)
		else $error("state not cleared after end of string");

	// a bundle never carries more results than its slots
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bundle_push |-> bundle.cnt <= 3'(qspd_pkg::MAX_RES))
		else $error("bundle count out of range");

	// a pending second digit only follows a percent sign
	a_digit_order: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_d == ESC_DIGIT |-> phase_q == ESC_PCT)
		else $error("escape digit phase entered out of order");

endmodule

// ===== rtl/qspd_fifo.sv =====
// short bundle queue between front end and back end
module qspd_fifo #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  qspd_pkg::bundle_t wr_data,
	output logic              full,
	input  logic              rd_en,
	output qspd_pkg::bundle_t rd_data,
	output logic              empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	qspd_pkg::bundle_t slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_wr, do_rd;

	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign rd_data = slot_q[rd_ptr_q];

	// slot storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// the front end must respect full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("bundle written into a full queue");

	// fill count tracks the pointer distance
	a_count_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		!full && !empty |-> wr_ptr_q != rd_ptr_q)
		else $error("queue pointers disagree with fill count");

endmodule

// ===== rtl/qspd_back.sv =====
// back end: hands out the results of the head bundle one item at a time
module qspd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  qspd_pkg::bundle_t head,
	input  logic              q_empty,
	output logic              q_pop,
	output logic [1:0]        kind,
	output logic [7:0]        out_byte,
	output logic              run_last,
	output logic              empty,
	input  logic              pop
);

	logic [1:0]      idx_q;
	qspd_pkg::res_t  cur;
	logic            take;

	// current slot of the head bundle
	assign cur      = head.res[idx_q];
	assign kind     = cur.kind;
	assign out_byte = cur.data;
	assign run_last = ({1'b0, idx_q} == head.cnt - 3'd1);
	assign empty    = q_empty;
	assign take     = pop && !q_empty;
	assign q_pop    = take && run_last;

	// slot index within the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= run_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	// the slot index stays inside the head bundle
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> {1'b0, idx_q} < head.cnt)
		else $error("slot index beyond head bundle");

	// index restarts at the first slot after a bundle is finished
	a_idx_restart: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> idx_q == 2'd0)
		else $error("slot index not restarted");

endmodule

// ===== rtl/query_string_pair_decoder.sv =====
// top level of the query string pair decoder
//
//  channel  | ports                       | handshake
//  ---------+-----------------------------+------------------------------
//  input    | in_byte, in_last            | push / full, taken on push & !full
//  result   | kind, out_byte, run_last    | empty / pop, taken on pop & !empty
//
// the front end decodes one input item per cycle, while full is low, into a bundle of 0
// to 4 results. the back end hands out one result item per cycle while pop is high, so
// an input item that causes k results holds the back end for k pops; items with one or no
// result flow at one per cycle. full rises only when the DEPTH-entry bundle queue is full.
// reset clears the scanner state, the queue and the slot index; queue slots are not reset.
module query_string_pair_decoder #(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       push,
	output logic       full,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       empty,
	input  logic       pop
);

	qspd_pkg::bundle_t wr_bundle, head;
	logic              wr_en, q_full, q_empty, q_pop;

	assign full = q_full;

	// scanner and bundle builder
	qspd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (push),
		.in_byte     (in_byte),
		.in_last     (in_last),
		.q_full      (q_full),
		.bundle_push (wr_en),
		.bundle      (wr_bundle)
	);

	// bundle queue
	qspd_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_bundle),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (head),
		.empty   (q_empty)
	);

	// result serialiser
	qspd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.kind     (kind),
		.out_byte (out_byte),
		.run_last (run_last),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

// ===== verif/query_string_pair_decoder_tb.sv =====
// testbench for the query string pair decoder: directed and random query strings, checked against a predictor
`timescale 1ns / 100ps

module query_string_pair_decoder_tb;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned PHASE_ITEMS = 44;

	// predictor of the decoder and store of the decoded results still to come
	class pair_decode_board;
		typedef struct {
			qspd_pkg::kind_t kind;
			logic [7:0]      data;
			logic            run_last;
		} dec_res_t;

		dec_res_t    expected_results[$];
		dec_res_t    step_res[$];
		logic [1:0]  esc_phase;
		logic [7:0]  held_digit;
		logic        in_value;
		logic        name_seen;
		int unsigned errors;

		function new();
			clear_scan();
			errors = 0;
		endfunction

		function void clear_scan();
			esc_phase  = 2'd0;
			held_digit = 8'h00;
			in_value   = 1'b0;
			name_seen  = 1'b0;
		endfunction

		function bit is_hex_digit(logic [7:0] c);
			return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
				(c >= 8'h61 && c <= 8'h66);
		endfunction

		function logic [3:0] hex_nibble(logic [7:0] c);
			logic [7:0] v;
			if (c <= 8'h39) begin
				v = c - 8'h30;
			end else if (c <= 8'h46) begin
				v = c - 8'h41 + 8'd10;
			end else begin
				v = c - 8'h61 + 8'd10;
			end
			return v[3:0];
		endfunction

		function qspd_pkg::kind_t piece_kind();
			return in_value ? qspd_pkg::KIND_VALUE : qspd_pkg::KIND_NAME;
		endfunction

		// value bytes and pair ends of a pair with an empty name are dropped
		function void emit(qspd_pkg::kind_t k, logic [7:0] b);
			dec_res_t r;
			if (k != qspd_pkg::KIND_NAME && !name_seen)
				return;
			if (step_res.size() >= qspd_pkg::MAX_RES)
				return;
			r.kind     = k;
			r.data     = b;
			r.run_last = 1'b0;
			step_res.insert(step_res.size(), r);
		endfunction

		// pending escape given back literally
		function void flush_escape();
			if (esc_phase == 2'd1) begin
				emit(piece_kind(), qspd_pkg::CH_PCT);
			end else if (esc_phase == 2'd2) begin
				emit(piece_kind(), qspd_pkg::CH_PCT);
				emit(piece_kind(), held_digit);
			end
			esc_phase = 2'd0;
		endfunction

		// decode one accepted item into its expected results
		function void note_item(logic [7:0] c, logic last);
			bit consumed;
			bit closed;
			consumed = 0;
			closed   = 0;
			step_res.delete();
			if (!in_value && c != qspd_pkg::CH_AMP && c != qspd_pkg::CH_EQ)
				name_seen = 1'b1;

			// escape in progress
			if (esc_phase == 2'd1) begin
				if (is_hex_digit(c)) begin
					esc_phase  = 2'd2;
					held_digit = c;
					consumed   = 1;
				end else begin
					flush_escape();
				end
			end else if (esc_phase == 2'd2) begin
				if (is_hex_digit(c)) begin
					emit(piece_kind(), {hex_nibble(held_digit), hex_nibble(c)});
					esc_phase  = 2'd0;
					held_digit = 8'h00;
					consumed   = 1;
				end else begin
					flush_escape();
				end
			end

			// ordinary scan of the byte
			if (!consumed) begin
				if (c == qspd_pkg::CH_AMP) begin
					emit(qspd_pkg::KIND_END, 8'h00);
					in_value  = 1'b0;
					name_seen = 1'b0;
					closed    = 1;
				end else if (c == qspd_pkg::CH_EQ && !in_value) begin
					in_value = 1'b1;
				end else if (c == qspd_pkg::CH_PLUS) begin
					emit(piece_kind(), qspd_pkg::CH_SPACE);
				end else if (c == qspd_pkg::CH_PCT) begin
					esc_phase = 2'd1;
				end else begin
					emit(piece_kind(), c);
				end
			end

			// end of the query string
			if (last) begin
				flush_escape();
				if (!closed)
					emit(qspd_pkg::KIND_END, 8'h00);
				clear_scan();
			end

			if (step_res.size() > 0)
				step_res[step_res.size()-1].run_last = 1'b1;
			foreach (step_res[i])
				expected_results.insert(expected_results.size(), step_res[i]);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(logic [1:0] k, logic [7:0] b, logic rl);
			dec_res_t e;
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual kind %h byte %h",
					$time, k, b);
				errors++;
				return;
			end
			e = expected_results[0];
			expected_results.delete(0);
			compare_field("kind", {6'd0, e.kind}, {6'd0, k});
			compare_field("out_byte", e.data, b);
			compare_field("run_last", {7'd0, e.run_last}, {7'd0, rl});
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       run_last;
	logic       empty;
	logic       pop = 1'b0;

	pair_decode_board board = new();

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_left = 0;
	bit          hold_req = 0;

	query_string_pair_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.out_byte (out_byte),
		.run_last (run_last),
		.empty    (empty),
		.pop      (pop)
	);

	// clock
	always #1 clk = ~clk;

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk) cycle_count++;
		$display("simulation failed");
		$finish;
	end

	// receiver: check each popped item, stall at random or for a long hold-off
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			board.check_result(kind, out_byte, run_last);
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// offer one item and wait until it is taken
	task automatic send_item(input logic [7:0] b, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		in_byte <= b;
		in_last <= l;
		do
			@(posedge clk);
		while (full);
		board.note_item(b, l);
		items_sent++;
	endtask

	task automatic send_text(input string s, input bit mark_last);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], mark_last && (i == s.len() - 1));
	endtask

	function automatic logic [7:0] hex_char();
		int unsigned r;
		r = $urandom_range(21);
		if (r < 10)
			return 8'(8'h30 + r);
		else if (r < 16)
			return 8'(8'h61 + r - 10);
		return 8'(8'h41 + r - 16);
	endfunction

	// one random character of a piece, possibly several bytes
	task automatic add_piece_char(ref logic [7:0] q[$]);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 40) begin
			q.insert(q.size(), 8'($urandom_range(8'h30, 8'h7a)));
		end else if (r < 55) begin
			q.insert(q.size(), qspd_pkg::CH_PLUS);
		end else if (r < 75) begin
			q.insert(q.size(), qspd_pkg::CH_PCT);
			q.insert(q.size(), hex_char());
			q.insert(q.size(), hex_char());
		end else if (r < 85) begin
			// broken escape
			q.insert(q.size(), qspd_pkg::CH_PCT);
			if ($urandom_range(1))
				q.insert(q.size(), hex_char());
			case ($urandom_range(3))
				0: q.insert(q.size(), "z");
				1: q.insert(q.size(), qspd_pkg::CH_PCT);
				2: q.insert(q.size(), qspd_pkg::CH_PLUS);
				default: q.insert(q.size(), "G");
			endcase
		end else if (r < 95) begin
			q.insert(q.size(), 8'($urandom_range(255)));
		end else begin
			q.insert(q.size(), qspd_pkg::CH_EQ);
		end
	endtask

	// a whole query string of random pairs, last byte marked
	task automatic send_random_query();
		logic [7:0]  q[$];
		int unsigned n_pairs;
		n_pairs = $urandom_range(1, 4);
		for (int p = 0; p < n_pairs; p++) begin
			if (p > 0)
				q.insert(q.size(), qspd_pkg::CH_AMP);
			repeat ($urandom_range(0, 3))
				add_piece_char(q);
			if ($urandom_range(3) != 0) begin
				q.insert(q.size(), qspd_pkg::CH_EQ);
				repeat ($urandom_range(0, 3))
					add_piece_char(q);
			end
		end
		if ($urandom_range(5) == 0)
			q.insert(q.size(), qspd_pkg::CH_AMP);
		if (q.size() == 0)
			q.insert(q.size(), 8'($urandom_range(255)));
		foreach (q[i])
			send_item(q[i], i == q.size() - 1);
	endtask

	task automatic run_phase(input int unsigned idle, input int unsigned stall);
		int unsigned target;
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		target = items_sent + PHASE_ITEMS;
		while (items_sent < target)
			send_random_query();
	endtask

	// main sequence
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hex of both cases, plus, literal second equals, percent at the string end
		send_text("%4a+b=%7E=%", 1);
		// empty name with a value, then a lone ampersand
		send_text("=v&", 0);
		send_text("&", 0);
		// escape with one digit cut off by an ampersand
		send_text("%4&", 0);
		send_item(8'h00, 0);
		send_item(8'hFF, 0);
		// broken escape, then the most results one item can cause
		send_text("%g%4%", 1);

		run_phase(0, 0);
		run_phase(56, 0);
		run_phase(0, 56);
		run_phase(8, 8);
		// receiver holds off so the block fills and stalls its input
		hold_req = 1;
		run_phase(0, 0);

		push <= 1'b0;
		recv_stall_pct = 0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.errors == 0 && board.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/qspd_pkg.sv
rtl/qspd_front.sv
rtl/qspd_fifo.sv
rtl/qspd_back.sv
rtl/query_string_pair_decoder.sv
verif/query_string_pair_decoder_tb.sv
